// ----- hdl/ult_pkg.sv -----
package ult_pkg;

  // field widths of the two channels
  localparam int CMD_W       = 3;
  localparam int VALUE_IN_W  = 32;
  localparam int INDEX_W     = 4;
  localparam int RANGE_W     = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int RD_OUT_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // command codes
  localparam cmd_t CMD_APPEND    = 3'd0;
  localparam cmd_t CMD_REMOVE_AT = 3'd1;
  localparam cmd_t CMD_REMOVE_RG = 3'd2;
  localparam cmd_t CMD_FIND_RM   = 3'd3;
  localparam cmd_t CMD_POSITION  = 3'd4;
  localparam cmd_t CMD_READ      = 3'd5;
  localparam cmd_t CMD_SORT      = 3'd6;

  // status codes
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

endpackage

// ----- hdl/ult_ram.sv -----
module ult_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ult_cmp.sv -----
module ult_cmp #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             eq,
  output logic             gt
);

  // unsigned magnitude compare shared by search and sort
  assign eq = (a == b);
  assign gt = (a > b);

endmodule

// ----- hdl/unordered_list_table.sv -----
// channel | direction | handshake            | payload
// in      | slave     | in_tvalid/in_tready  | in_tuser: cmd; in_tdata: value, index, range_end
// out     | master    | out_tvalid/out_tready| out_tdata: count, where_found, found,
//         |           |                      |            read_data, status
// one item at a time; in_tready is high only while the sequencer is idle.
// append writes in the dispatch step, read captures the entry in its read step, remove at index moves the
// last entry into the hole, remove range copies the tail down over the range when a tail moves,
// find remove and position scan from index 0 for the first match; all share the single RAM read
// port. sort is a bubble sort through the one comparator, at most count passes.
// synchronous active-low reset clears the count and control state; the store is not cleared.
// a waiting result holds the sequencer in its send step until out_tready takes it.
module unordered_list_table #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] value, [35:32] index, [40:36] range_end, rest zero
  input  logic [ult_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [ult_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] count, [9:5] where_found, [10] found, [42:11] read_data, [44:43] status
  output logic [ult_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import ult_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > RANGE_W) ? CW : RANGE_W;
  localparam int VW = VALUE_WIDTH;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_SORT = 3'd6;
  localparam logic [2:0] S_SEND = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                dv_r, dv_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [VW-1:0]       val_r, val_nxt;
  logic [INDEX_W-1:0]  ix_r, ix_nxt;
  logic [RANGE_W-1:0]  re_r, re_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       dk_r, dk_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [VW-1:0]       cur_r, cur_nxt;
  logic                swp_r, swp_nxt;
  logic [CW-1:0]       where_r, where_nxt;
  logic                fnd_r, fnd_nxt;
  logic [RD_OUT_W-1:0] rd_r, rd_nxt;
  status_t             st_r, st_nxt;
  logic [CW-1:0]       out_cnt_r, out_cnt_nxt;
  logic [CW-1:0]       out_where_r, out_where_nxt;
  logic                out_fnd_r, out_fnd_nxt;
  logic [RD_OUT_W-1:0] out_rd_r, out_rd_nxt;
  status_t             out_st_r, out_st_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [VW-1:0]       ram_rdata;
  logic [VW-1:0]       cmp_a;
  logic                cmp_eq;
  logic                cmp_gt;

  logic [CW-1:0]       cnt_m1;
  logic [XW-1:0]       cnt_x;
  logic [XW-1:0]       ix_x;
  logic [XW-1:0]       re_x;
  logic [CW-1:0]       gap;
  logic [CW-1:0]       copy_dst;
  logic [CW-1:0]       sort_dst;

  ult_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared comparator: search key for find remove and position, carried entry for sort
  assign cmp_a = (state_r == S_SORT) ? cur_r : val_r;

  ult_cmp #(
    .WIDTH (VW)
  ) u_cmp (
    .a  (cmp_a),
    .b  (ram_rdata),
    .eq (cmp_eq),
    .gt (cmp_gt)
  );

  // index arithmetic
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_x    = XW'(cnt_r);
  assign ix_x     = XW'(ix_r);
  assign re_x     = XW'(re_r);
  assign gap      = CW'(re_x - ix_x);
  assign copy_dst = dk_r - gap;
  assign sort_dst = dk_r - CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_st_r, out_rd_r, out_fnd_r,
                       COUNT_OUT_W'(out_where_r), COUNT_OUT_W'(out_cnt_r)};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    dv_nxt         = 1'b0;
    dk_nxt         = dk_r;
    k_nxt          = k_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    ix_nxt         = ix_r;
    re_nxt         = re_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    swp_nxt        = swp_r;
    where_nxt      = where_r;
    fnd_nxt        = fnd_r;
    rd_nxt         = rd_r;
    st_nxt         = st_r;
    out_cnt_nxt    = out_cnt_r;
    out_where_nxt  = out_where_r;
    out_fnd_nxt    = out_fnd_r;
    out_rd_nxt     = out_rd_r;
    out_st_nxt     = out_st_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = k_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          val_nxt   = VW'(in_tdata[VALUE_IN_W-1:0]);
          ix_nxt    = in_tdata[VALUE_IN_W +: INDEX_W];
          re_nxt    = in_tdata[VALUE_IN_W + INDEX_W +: RANGE_W];
          state_nxt = S_DISP;
        end
      end

      // check the item and start its walk
      S_DISP: begin
        where_nxt = '0;
        fnd_nxt   = 1'b0;
        rd_nxt    = '0;
        st_nxt    = ST_OK;
        k_nxt     = '0;
        state_nxt = S_SEND;
        case (cmd_r)
          CMD_APPEND: begin
            if (cnt_r == CW'(DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[AW-1:0];
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + CW'(1);
            end
          end
          CMD_REMOVE_AT: begin
            if (ix_x >= cnt_x) begin
              st_nxt = ST_BAD;
            end else begin
              pos_nxt   = ix_x[AW-1:0];
              ram_raddr = cnt_m1[AW-1:0];
              state_nxt = S_MOVE;
            end
          end
          CMD_REMOVE_RG: begin
            if (ix_x >= re_x || re_x > cnt_x) begin
              st_nxt = ST_BAD;
            end else begin
              k_nxt     = CW'(re_x);
              state_nxt = S_COPY;
            end
          end
          CMD_FIND_RM, CMD_POSITION: begin
            state_nxt = S_SCAN;
          end
          CMD_READ: begin
            if (ix_x >= cnt_x) begin
              st_nxt = ST_BAD;
            end else begin
              ram_raddr = ix_x[AW-1:0];
              state_nxt = S_RD;
            end
          end
          CMD_SORT: begin
            if (cnt_r > CW'(1)) begin
              swp_nxt   = 1'b0;
              state_nxt = S_SORT;
            end
          end
          default: begin
            state_nxt = S_SEND;
          end
        endcase
      end

      // linear search for the first match, one read per cycle
      S_SCAN: begin
        if (dv_r && cmp_eq) begin
          where_nxt = dk_r;
          fnd_nxt   = 1'b1;
          if (cmd_r == CMD_FIND_RM) begin
            pos_nxt   = dk_r[AW-1:0];
            ram_raddr = cnt_m1[AW-1:0];
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_SEND;
          end
        end else if (!dv_r && k_r >= cnt_r) begin
          where_nxt = cnt_r;
          state_nxt = S_SEND;
        end else if (k_r < cnt_r) begin
          k_nxt  = k_r + CW'(1);
          dv_nxt = 1'b1;
          dk_nxt = k_r;
        end
      end

      // last entry fills the hole
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = ram_rdata;
        cnt_nxt   = cnt_m1;
        state_nxt = S_SEND;
      end

      // tail shifts down over the removed range
      S_COPY: begin
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = copy_dst[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (k_r < cnt_r) begin
          k_nxt  = k_r + CW'(1);
          dv_nxt = 1'b1;
          dk_nxt = k_r;
        end else if (!dv_r) begin
          cnt_nxt   = cnt_r - gap;
          state_nxt = S_SEND;
        end
      end

      S_RD: begin
        rd_nxt    = RD_OUT_W'(ram_rdata);
        state_nxt = S_SEND;
      end

      // bubble pass: carry the larger entry up, write the smaller behind
      S_SORT: begin
        if (dv_r) begin
          if (dk_r == '0) begin
            cur_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = sort_dst[AW-1:0];
            ram_wdata = cmp_gt ? ram_rdata : cur_r;
            cur_nxt   = cmp_gt ? cur_r : ram_rdata;
            if (cmp_gt) begin
              swp_nxt = 1'b1;
            end
          end
        end
        if (k_r < cnt_r) begin
          k_nxt  = k_r + CW'(1);
          dv_nxt = 1'b1;
          dk_nxt = k_r;
        end else if (!dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m1[AW-1:0];
          ram_wdata = cur_r;
          if (swp_r) begin
            k_nxt   = '0;
            swp_nxt = 1'b0;
          end else begin
            state_nxt = S_SEND;
          end
        end
      end

      // hand the result to the output register once it is free
      S_SEND: begin
        if (!out_tvalid_r || out_tready) begin
          out_cnt_nxt    = cnt_r;
          out_where_nxt  = where_r;
          out_fnd_nxt    = fnd_r;
          out_rd_nxt     = rd_r;
          out_st_nxt     = st_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      dv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      dv_r         <= dv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    ix_r        <= ix_nxt;
    re_r        <= re_nxt;
    k_r         <= k_nxt;
    dk_r        <= dk_nxt;
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    swp_r       <= swp_nxt;
    where_r     <= where_nxt;
    fnd_r       <= fnd_nxt;
    rd_r        <= rd_nxt;
    st_r        <= st_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_where_r <= out_where_nxt;
    out_fnd_r   <= out_fnd_nxt;
    out_rd_r    <= out_rd_nxt;
    out_st_r    <= out_st_nxt;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("live count above depth");

  a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_st_r == ST_FULL |-> out_cnt_r == CW'(DEPTH))
    else $error("full status with room left");

  a_where_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_where_r <= out_cnt_r)
    else $error("match index beyond count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule
